@@ hw/rtl/inflated_occupancy_check_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the inflated occupancy check block
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef INFLATED_OCCUPANCY_CHECK_CORE_MACROS_SVH
`define INFLATED_OCCUPANCY_CHECK_CORE_MACROS_SVH

// property checked at every clock edge outside reset
`define IOC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// implication checked at every clock edge outside reset
`define IOC_ASSERT_IMPL(label, pre, post, msg) \
    `IOC_ASSERT(label, (pre) |-> (post), msg)

`endif

@@ hw/rtl/ioc_pkg.sv @@
// ----------------------------------------------------------------------------
// ioc_pkg
// Types, field widths, register indexes and defaults of the occupancy check.
// ----------------------------------------------------------------------------
package ioc_pkg;

    localparam int DEF_MAX_WIDTH     = 256;
    localparam int DEF_MAX_HEIGHT    = 256;
    localparam int DEF_MAX_INFLATION = 15;

    localparam int CELL_W    = 10;   // signed cell coordinate
    localparam int VALUE_W   = 8;    // signed occupancy value
    localparam int GRID_W    = 9;    // grid_width / grid_height
    localparam int INFL_W    = 4;    // inflation_cells
    localparam int THR_W     = 7;    // occupied_threshold
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 9;

    typedef logic signed [CELL_W-1:0]  t_coord;
    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [CFG_IDX_W-1:0]      t_cfg_idx;
    typedef logic [CFG_DAT_W-1:0]      t_cfg_dat;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam t_cfg_idx REG_GRID_WIDTH  = 2'd0;
    localparam t_cfg_idx REG_GRID_HEIGHT = 2'd1;
    localparam t_cfg_idx REG_INFLATION   = 2'd2;
    localparam t_cfg_idx REG_THRESHOLD   = 2'd3;

    localparam logic [GRID_W-1:0] RST_GRID_WIDTH  = 9'd256;
    localparam logic [GRID_W-1:0] RST_GRID_HEIGHT = 9'd256;
    localparam logic [INFL_W-1:0] RST_INFLATION   = 4'd7;
    localparam logic [THR_W-1:0]  RST_THRESHOLD   = 7'd50;

    localparam t_value UNKNOWN_CELL = -8'sd1;

endpackage

@@ hw/rtl/ioc_if.sv @@
// ----------------------------------------------------------------------------
// ioc_if
// Valid/ready channels of the occupancy check: items in, results out, config.
// ----------------------------------------------------------------------------
interface ioc_in_if;
    import ioc_pkg::*;

    logic   valid;
    logic   ready;
    logic   operation;
    t_coord cell_x;
    t_coord cell_y;
    t_value cell_value;

    modport source (output valid, operation, cell_x, cell_y, cell_value, input ready);
    modport sink   (input valid, operation, cell_x, cell_y, cell_value, output ready);
endinterface

interface ioc_out_if;
    logic valid;
    logic ready;
    logic occupied;
    logic out_of_bounds;

    modport source (output valid, occupied, out_of_bounds, input ready);
    modport sink   (input valid, occupied, out_of_bounds, output ready);
endinterface

interface ioc_cfg_if;
    import ioc_pkg::*;

    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_cfg_dat data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/ioc_ram.sv @@
// ----------------------------------------------------------------------------
// ioc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ioc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/inflated_occupancy_check_core.sv @@
// ----------------------------------------------------------------------------
// inflated_occupancy_check_core
// Occupancy grid store with an inflated-window collision query.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  : item channel. operation OP_WRITE stores cell_value at
//           (cell_x, cell_y) when inside the grid, no result. OP_QUERY scans the
//           (2r+1) x (2r+1) window around the cell, r = inflation_cells.
//   o_out : one result per query: occupied, out_of_bounds.
//   i_cfg : register writes (grid_width, grid_height, inflation_cells,
//           occupied_threshold), always ready; write only while idle.
// Operation:
//   write  : goes into the grid RAM when taken; no result.
//   query  : the scan steps through one window cell per cycle, reading the
//            in-grid cells through the single read port of the grid RAM,
//            then the drain and done states follow. Before any map cell has been
//            written a query skips the scan and answers occupied.
//   One item is in work at a time; i_in.ready is high only while idle and
//   rises again in the cycle the query result turns valid.
// Reset clears the registers to their defaults and marks the map unloaded;
// the grid RAM is not cleared. A stalled o_out holds its result; the block
// keeps taking writes and one more query, which waits at its end for the output.
// ----------------------------------------------------------------------------
`include "inflated_occupancy_check_core_macros.svh"

module inflated_occupancy_check_core #(
    parameter int MAX_WIDTH     = ioc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = ioc_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_INFLATION = ioc_pkg::DEF_MAX_INFLATION
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ioc_in_if.sink     i_in,
    ioc_out_if.source  o_out,
    ioc_cfg_if.sink    i_cfg
);
    import ioc_pkg::*;

    localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int AW    = XW + YW;
    localparam int DEPTH = 1 << AW;
    localparam int RW    = (MAX_INFLATION > 0) ? $clog2(MAX_INFLATION + 1) : 1;
    localparam int DW    = RW + 1;
    localparam int CW    = ((CELL_W > RW) ? CELL_W : RW) + 2;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    // configuration registers
    logic [GRID_W-1:0] r_grid_width;
    logic [GRID_W-1:0] r_grid_height;
    logic [INFL_W-1:0] r_inflation;
    logic [THR_W-1:0]  r_threshold;

    // control
    logic [1:0]        r_state;
    logic              r_map_loaded;
    logic              r_rd_vld;
    logic              r_out_vld;

    // query context
    t_coord            r_cx;
    t_coord            r_cy;
    logic [GRID_W-1:0] r_w;
    logic [GRID_W-1:0] r_h;
    logic [RW-1:0]     r_rad;
    logic [THR_W-1:0]  r_thr;
    logic signed [DW-1:0] r_dx;
    logic signed [DW-1:0] r_dy;
    logic              r_outside;
    logic              r_blocked;
    logic              r_res_occ;
    logic              r_res_oob;
    logic              r_out_occ;
    logic              r_out_oob;

    logic [GRID_W-1:0] w_eff_w;
    logic [GRID_W-1:0] w_eff_h;
    logic [RW-1:0]     w_eff_rad;
    logic              w_in_fire;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic signed [CW-1:0] w_x;
    logic signed [CW-1:0] w_y;
    logic              w_win_in;
    logic              w_re;
    logic [AW-1:0]     w_raddr;
    logic [VALUE_W-1:0] w_rdata;
    t_value            w_val;
    logic              w_hit;
    logic signed [DW-1:0] w_rad_s;
    logic              w_out_free;

    function automatic logic f_in_grid(
        input logic signed [CW-1:0] x,
        input logic signed [CW-1:0] y,
        input logic [GRID_W-1:0]    w,
        input logic [GRID_W-1:0]    h
    );
        logic signed [CW-1:0] ws;
        logic signed [CW-1:0] hs;
        ws = $signed(CW'({1'b0, w}));
        hs = $signed(CW'({1'b0, h}));
        return (x >= 0) && (x < ws) && (y >= 0) && (y < hs);
    endfunction

    // geometry saturated to the storage limits
    always_comb begin
        w_eff_w   = (int'(r_grid_width) > MAX_WIDTH) ? GRID_W'(MAX_WIDTH) : r_grid_width;
        w_eff_h   = (int'(r_grid_height) > MAX_HEIGHT) ? GRID_W'(MAX_HEIGHT) : r_grid_height;
        w_eff_rad = (int'(r_inflation) > MAX_INFLATION) ? RW'(MAX_INFLATION)
                                                        : RW'(r_inflation);
    end

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_in_fire   = i_in.valid && i_in.ready;
    assign w_out_free  = !r_out_vld || o_out.ready;

    // map write path
    always_comb begin
        w_we = w_in_fire && (i_in.operation == OP_WRITE)
            && f_in_grid(CW'(i_in.cell_x), CW'(i_in.cell_y), w_eff_w, w_eff_h);
        w_waddr = {YW'($unsigned(i_in.cell_y)), XW'($unsigned(i_in.cell_x))};
    end

    // window scan address
    always_comb begin
        w_x      = CW'(r_cx) + CW'(r_dx);
        w_y      = CW'(r_cy) + CW'(r_dy);
        w_win_in = f_in_grid(w_x, w_y, r_w, r_h);
        w_re     = (r_state == ST_SCAN) && w_win_in;
        w_raddr  = {YW'($unsigned(w_y)), XW'($unsigned(w_x))};
        w_rad_s  = $signed({1'b0, r_rad});
    end

    // cell read back in the cycle after its address
    always_comb begin
        w_val = $signed(w_rdata);
        w_hit = r_rd_vld && (($signed({w_val[VALUE_W-1], w_val}) >
                              $signed({2'b00, r_thr})) || (w_val == UNKNOWN_CELL));
    end

    ioc_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_grid_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_in.cell_value),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= RST_GRID_WIDTH;
            r_grid_height <= RST_GRID_HEIGHT;
            r_inflation   <= RST_INFLATION;
            r_threshold   <= RST_THRESHOLD;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_GRID_WIDTH:  r_grid_width  <= i_cfg.data[GRID_W-1:0];
                REG_GRID_HEIGHT: r_grid_height <= i_cfg.data[GRID_W-1:0];
                REG_INFLATION:   r_inflation   <= i_cfg.data[INFL_W-1:0];
                REG_THRESHOLD:   r_threshold   <= i_cfg.data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_map_loaded <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            // in ST_DONE the output register is either stalled or reloaded below
            if (o_out.ready && (r_state != ST_DONE)) begin
                r_out_vld <= 1'b0;
            end
            if (w_we) begin
                r_map_loaded <= 1'b1;
            end
            r_rd_vld <= w_re;

            case (r_state)
                ST_IDLE: begin
                    if (w_in_fire && (i_in.operation == OP_QUERY)) begin
                        r_cx      <= i_in.cell_x;
                        r_cy      <= i_in.cell_y;
                        r_w       <= w_eff_w;
                        r_h       <= w_eff_h;
                        r_rad     <= w_eff_rad;
                        r_thr     <= r_threshold;
                        r_dx      <= -$signed({1'b0, w_eff_rad});
                        r_dy      <= -$signed({1'b0, w_eff_rad});
                        r_outside <= 1'b0;
                        r_blocked <= 1'b0;
                        if (r_map_loaded) begin
                            r_state <= ST_SCAN;
                        end else begin
                            r_res_occ <= 1'b1;
                            r_res_oob <= 1'b0;
                            r_state   <= ST_DONE;
                        end
                    end
                end
                ST_SCAN: begin
                    if (!w_win_in) begin
                        r_outside <= 1'b1;
                    end
                    if (w_hit) begin
                        r_blocked <= 1'b1;
                    end
                    if (r_dy == w_rad_s) begin
                        r_dy <= -w_rad_s;
                        if (r_dx == w_rad_s) begin
                            r_state <= ST_DRAIN;
                        end else begin
                            r_dx <= r_dx + DW'(1);
                        end
                    end else begin
                        r_dy <= r_dy + DW'(1);
                    end
                end
                ST_DRAIN: begin
                    r_res_occ <= r_outside || r_blocked || w_hit;
                    r_res_oob <= r_outside;
                    r_state   <= ST_DONE;
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_out_vld <= 1'b1;
                        r_out_occ <= r_res_occ;
                        r_out_oob <= r_res_oob;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.occupied      = r_out_occ;
    assign o_out.out_of_bounds = r_out_oob;

    `IOC_ASSERT_IMPL(a_oob_implies_occ, r_out_vld && r_out_oob, r_out_occ, "oob without occupied")
    `IOC_ASSERT_IMPL(a_write_only_idle, w_we, r_state == ST_IDLE, "grid write outside idle")
    `IOC_ASSERT_IMPL(a_rd_scan, r_rd_vld, r_state == ST_SCAN || r_state == ST_DRAIN, "stray read")
    `IOC_ASSERT_IMPL(a_drain_src, r_state == ST_DRAIN, $past(r_state) == ST_SCAN, "bad drain")

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for inflated_occupancy_check_core. Loads occupancy
// maps, checks queries at the grid edges and outside the grid, tries zero and
// oversized geometry and threshold and radius extremes, then runs random
// phases. Each transfer into the block is folded into a local model of the
// grid, and every result is compared against that model.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ioc_pkg::*;

    localparam int RANDOM_ITEMS    = 900;
    localparam int PICKS_PER_PHASE = 30;
    localparam int PLANNED_PHASES  = 10;
    localparam int GRID_CELLS      = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

    typedef struct packed {
        logic   operation;
        t_coord cell_x;
        t_coord cell_y;
        t_value cell_value;
    } map_item_t;

    typedef struct packed {
        logic occupied;
        logic out_of_bounds;
    } verdict_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_HELD} rx_pattern_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    ioc_in_if  in_ch ();
    ioc_out_if out_ch ();
    ioc_cfg_if cfg_ch ();

    inflated_occupancy_check_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // grid as the block should hold it, advanced at each item transfer
    t_value grid_model [GRID_CELLS];
    bit     model_loaded = 1'b0;
    int     model_w, model_h, model_r, model_thr;

    // what the generator has already queued, so no query reads unwritten RAM
    bit     cell_written [GRID_CELLS];
    bit     gen_loaded   = 1'b0;
    int     item_total   = 0;
    int     obstacle_pm  = 0;

    map_item_t map_ops_q [$];
    verdict_t  verdict_q [$];
    int        mismatch_count = 0;

    int phase_plan [PLANNED_PHASES][4] = '{
        '{256, 256,  3,  50},
        '{  1,   1,  0,   0},
        '{  0,   5,  2,  50},
        '{  7,   0,  1,  50},
        '{511,   3,  3, 100},
        '{  2, 300, 15, 127},
        '{256,   1, 15,  20},
        '{  1, 256,  8,  64},
        '{ 16,  16,  0, 101},
        '{ 12,   9,  4,  30}
    };

    always #5 i_clk = ~i_clk;

    function automatic bit in_map(int x, int y);
        return x >= 0 && x < model_w && y >= 0 && y < model_h;
    endfunction

    function automatic void predict_verdict(map_item_t it);
        int       cx, cy, x, y, v;
        verdict_t vd;
        cx = $signed(it.cell_x);
        cy = $signed(it.cell_y);
        if (it.operation == OP_WRITE) begin
            if (in_map(cx, cy)) begin
                grid_model[cy * DEF_MAX_WIDTH + cx] = it.cell_value;
                model_loaded = 1'b1;
            end
            return;
        end
        vd = '{occupied: 1'b1, out_of_bounds: 1'b0};
        if (model_loaded) begin
            vd = '0;
            for (int dy = -model_r; dy <= model_r; dy++) begin
                for (int dx = -model_r; dx <= model_r; dx++) begin
                    x = cx + dx;
                    y = cy + dy;
                    if (!in_map(x, y)) begin
                        vd.out_of_bounds = 1'b1;
                    end else begin
                        v = $signed(grid_model[y * DEF_MAX_WIDTH + x]);
                        if (v > model_thr || v == UNKNOWN_CELL)
                            vd.occupied = 1'b1;
                    end
                end
            end
            vd.occupied = vd.occupied | vd.out_of_bounds;
        end
        verdict_q.insert(verdict_q.size(), vd);
    endfunction

    function automatic void push_item(logic op, int x, int y, int v);
        map_item_t it;
        it.operation  = op;
        it.cell_x     = t_coord'(x);
        it.cell_y     = t_coord'(y);
        it.cell_value = t_value'(v);
        map_ops_q.insert(map_ops_q.size(), it);
        item_total++;
        if (op == OP_WRITE && in_map(x, y)) begin
            cell_written[y * DEF_MAX_WIDTH + x] = 1'b1;
            gen_loaded = 1'b1;
        end
    endfunction

    // mostly free values, obstacles and unknowns at the phase's rate
    function automatic int fill_value();
        if ($urandom_range(0, 999) < obstacle_pm) begin
            case ($urandom_range(0, 2))
                0: return UNKNOWN_CELL;
                1: return int'($urandom_range(0, 255)) - 128;
                default: return (model_thr < 127) ? int'($urandom_range(model_thr + 1, 127))
                                                  : UNKNOWN_CELL;
            endcase
        end
        if ($urandom_range(0, 1))
            return int'($urandom_range(0, model_thr));
        return -int'($urandom_range(2, 128));
    endfunction

    // once the map counts as loaded, every in-grid window cell must hold data
    function automatic void gen_query(int x, int y);
        if (gen_loaded) begin
            for (int yy = y - model_r; yy <= y + model_r; yy++) begin
                for (int xx = x - model_r; xx <= x + model_r; xx++) begin
                    if (in_map(xx, yy) && !cell_written[yy * DEF_MAX_WIDTH + xx])
                        push_item(OP_WRITE, xx, yy, fill_value());
                end
            end
        end
        push_item(OP_QUERY, x, y, int'($urandom_range(0, 255)));
    endfunction

    function automatic int pick_coord(int extent, int lo, int span);
        int p;
        p = $urandom_range(0, 99);
        if (p < 70)
            return lo + int'($urandom_range(0, span - 1));
        if (p < 82)
            return ($urandom_range(0, 1) ? 0 : extent - 1)
                   + int'($urandom_range(0, 2 * model_r + 2)) - model_r - 1;
        if (p < 90)
            return $urandom_range(0, 1) ? -256 + int'($urandom_range(0, 3))
                                        : 511 - int'($urandom_range(0, 3));
        return int'($urandom_range(0, 767)) - 256;
    endfunction

    function automatic int pick_extent();
        int p;
        p = $urandom_range(0, 19);
        if (p == 0)
            return 0;
        if (p == 1)
            return $urandom_range(257, 511);
        if (p <= 3)
            return $urandom_range(200, 256);
        return $urandom_range(1, 24);
    endfunction

    // wait for an idle block; the tail covers a write still in work
    task automatic settle();
        while (map_ops_q.size() > 0 || in_ch.valid || verdict_q.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int value);
        t_cfg_dat data;
        data = t_cfg_dat'(value);
        // bits above the register width should be dropped
        if (idx == REG_INFLATION)
            data[CFG_DAT_W-1:INFL_W] = (CFG_DAT_W - INFL_W)'($urandom());
        if (idx == REG_THRESHOLD)
            data[CFG_DAT_W-1:THR_W] = (CFG_DAT_W - THR_W)'($urandom());
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_GRID_WIDTH:  model_w = (data > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : data;
            REG_GRID_HEIGHT: model_h = (data > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : data;
            REG_INFLATION:   model_r = (data[INFL_W-1:0] > DEF_MAX_INFLATION) ?
                                       DEF_MAX_INFLATION : data[INFL_W-1:0];
            REG_THRESHOLD:   model_thr = data[THR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic run_phase(input int w, input int h, input int r, input int thr);
        int span_x, span_y, lo_x, lo_y, x, y, p;
        settle();
        write_reg(REG_GRID_WIDTH, w);
        write_reg(REG_GRID_HEIGHT, h);
        write_reg(REG_INFLATION, r);
        write_reg(REG_THRESHOLD, thr);
        obstacle_pm = 700 / ((2 * model_r + 1) * (2 * model_r + 1));
        if (obstacle_pm > 300)
            obstacle_pm = 300;
        // keep most queries in a small patch so large grids need few fills
        span_x = (model_w > 32) ? 4 : ((model_w > 8) ? 8 : ((model_w > 0) ? model_w : 1));
        span_y = (model_h > 32) ? 4 : ((model_h > 8) ? 8 : ((model_h > 0) ? model_h : 1));
        lo_x   = (model_w > span_x) ? $urandom_range(0, model_w - span_x) : 0;
        lo_y   = (model_h > span_y) ? $urandom_range(0, model_h - span_y) : 0;
        repeat (PICKS_PER_PHASE) begin
            p = $urandom_range(0, 99);
            x = pick_coord(model_w, lo_x, span_x);
            y = pick_coord(model_h, lo_y, span_y);
            if (p < 50) begin
                gen_query(x, y);
            end else if (p < 85) begin
                push_item(OP_WRITE, x, y, fill_value());
            end else begin
                x = $urandom_range(0, 1) ? -int'($urandom_range(1, 256))
                                         : model_w + int'($urandom_range(0, 511 - model_w));
                push_item(OP_WRITE, x, y, int'($urandom_range(0, 255)) - 128);
            end
        end
    endtask

    // item driver: bursts of random length, random gaps in between
    map_item_t drv_item   = '0;
    int        burst_left = 0;
    int        gap_left   = 0;

    always @(posedge i_clk) begin
        logic send;
        send = 1'b0;
        if (!i_rst_n) begin
            in_ch.valid      <= 1'b0;
            in_ch.operation  <= OP_WRITE;
            in_ch.cell_x     <= '0;
            in_ch.cell_y     <= '0;
            in_ch.cell_value <= '0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                predict_verdict(drv_item);
            if (!in_ch.valid || in_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (map_ops_q.size() > 0) begin
                    drv_item = map_ops_q.pop_front();
                    send = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                in_ch.valid      <= send;
                in_ch.operation  <= drv_item.operation;
                in_ch.cell_x     <= drv_item.cell_x;
                in_ch.cell_y     <= drv_item.cell_y;
                in_ch.cell_value <= drv_item.cell_value;
            end
        end
    end

    // result monitor with its own stall pattern
    rx_pattern_t rx_pattern = RX_OPEN;
    int          stall_tick = 0;

    always @(posedge i_clk) begin
        verdict_t want;
        logic     rdy;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (verdict_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, got occupied=%0b oob=%0b",
                             $time, out_ch.occupied, out_ch.out_of_bounds);
                end else begin
                    want = verdict_q.pop_front();
                    if (out_ch.occupied !== want.occupied) begin
                        mismatch_count++;
                        $display("%0t: occupied expected %0b, got %0b",
                                 $time, want.occupied, out_ch.occupied);
                    end
                    if (out_ch.out_of_bounds !== want.out_of_bounds) begin
                        mismatch_count++;
                        $display("%0t: out_of_bounds expected %0b, got %0b",
                                 $time, want.out_of_bounds, out_ch.out_of_bounds);
                    end
                end
            end
            stall_tick++;
            if (stall_tick % 97 == 0)
                rx_pattern = rx_pattern_t'($urandom_range(0, 3));
            case (rx_pattern)
                RX_OPEN:   rdy = 1'b1;
                RX_COIN:   rdy = 1'($urandom_range(0, 1));
                RX_SPARSE: rdy = (stall_tick % 6 == 0);
                default:   rdy = (stall_tick % 40) >= 25;
            endcase
            out_ch.ready <= rdy;
        end
    end

    initial begin
        int start_total;
        int extra_phases;
        int w, h;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = REG_GRID_WIDTH;
        cfg_ch.data      = '0;
        model_w   = RST_GRID_WIDTH;
        model_h   = RST_GRID_HEIGHT;
        model_r   = RST_INFLATION;
        model_thr = RST_THRESHOLD;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // nothing loaded yet, default geometry; outside writes must not load it
        gen_query(0, 0);
        gen_query(-256, -256);
        gen_query(511, 511);
        push_item(OP_WRITE, -1, 0, 5);
        push_item(OP_WRITE, 256, 3, 5);

        // tiny map, radius 1: threshold edge, unknown cell, window off the grid
        settle();
        write_reg(REG_GRID_WIDTH, 4);
        write_reg(REG_GRID_HEIGHT, 3);
        write_reg(REG_INFLATION, 1);
        write_reg(REG_THRESHOLD, 50);
        for (int yy = 0; yy < 3; yy++)
            for (int xx = 0; xx < 4; xx++)
                push_item(OP_WRITE, xx, yy, 0);
        gen_query(1, 1);
        push_item(OP_WRITE, 2, 1, 51);
        gen_query(1, 1);
        push_item(OP_WRITE, 2, 1, 50);
        gen_query(1, 1);
        push_item(OP_WRITE, 2, 1, UNKNOWN_CELL);
        gen_query(1, 1);
        gen_query(3, 2);

        start_total = item_total;
        for (int i = 0; i < PLANNED_PHASES; i++)
            run_phase(phase_plan[i][0], phase_plan[i][1], phase_plan[i][2], phase_plan[i][3]);

        extra_phases = 0;
        while (item_total - start_total < RANDOM_ITEMS || extra_phases < 2) begin
            w = pick_extent();
            h = pick_extent();
            run_phase(w, h,
                      (w > 32 || h > 32) ? $urandom_range(0, 4) :
                      (($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                   : $urandom_range(0, 5)),
                      $urandom_range(0, 127));
            extra_phases++;
        end

        settle();
        if (mismatch_count == 0 && verdict_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("Verification failed");
        $finish;
    end

endmodule

@@ inflated_occupancy_check_core.f @@
+incdir+hw/rtl
hw/rtl/ioc_pkg.sv
hw/rtl/ioc_if.sv
hw/rtl/ioc_ram.sv
hw/rtl/inflated_occupancy_check_core.sv
tb/tb.sv
